### rtl/text_display_refresh_engine_assert.svh
// Assertion macros for the text display refresh engine.
// Each macro expects signals named clk and rst in the including scope.
`ifndef TEXT_DISPLAY_REFRESH_ENGINE_ASSERT_SVH
`define TEXT_DISPLAY_REFRESH_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TDRE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TDRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tdre_pkg.sv
// Shared types, constants and helper functions for the text display refresh engine.
// No dependencies.
package tdre_pkg;

  localparam int LINES       = 4;
  localparam int LINE_W      = 2;
  localparam int COLUMNS_DEF = 20;

  localparam logic [7:0]  BLANK_CHAR = 8'h20;
  localparam logic [31:0] HASH_SEED  = 32'd5381;

  // Display address commands, one per line
  localparam logic [7:0] LINE_CMD_0 = 8'h02;
  localparam logic [7:0] LINE_CMD_1 = 8'hA0;
  localparam logic [7:0] LINE_CMD_2 = 8'hC0;
  localparam logic [7:0] LINE_CMD_3 = 8'hE0;

  typedef enum logic [2:0] {
    OP_SET_POS       = 3'd0,
    OP_PUT_CHAR      = 3'd1,
    OP_CLEAR_LINE    = 3'd2,
    OP_RIGHT_JUSTIFY = 3'd3,
    OP_REFRESH_LINE  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT_CMP,
    S_HASH,
    S_HASH_END,
    S_CMP,
    S_CMD,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // Text store control
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr_en;
    logic [LINE_W-1:0] clr_line;
  } store_ctl_t;

  // Hash unit control
  typedef struct packed {
    logic start;
    logic acc_en;
    logic store_en;
  } hash_ctl_t;

  function automatic logic [31:0] blank_hash(int cols);
    logic [31:0] h;
    h = HASH_SEED;
    for (int i = 0; i < cols; i++) begin
      h = (h << 5) + h + 32'(BLANK_CHAR);
    end
    return h;
  endfunction

  function automatic logic [7:0] line_cmd(logic [LINE_W-1:0] ln);
    logic [7:0] c;
    case (ln)
      2'd0:    c = LINE_CMD_0;
      2'd1:    c = LINE_CMD_1;
      2'd2:    c = LINE_CMD_2;
      default: c = LINE_CMD_3;
    endcase
    return c;
  endfunction

endpackage

### rtl/tdre_host_if.sv
// Host operation channel: valid/ready handshake with the operation payload.
// No dependencies.
interface tdre_host_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [1:0] line_sel;
  logic [4:0] column_sel;
  logic [7:0] char_code;
  logic       wrap;
  logic [7:0] text_length;

  modport source (
    output valid, operation, line_sel, column_sel, char_code, wrap, text_length,
    input  ready
  );
  modport sink (
    input  valid, operation, line_sel, column_sel, char_code, wrap, text_length,
    output ready
  );
endinterface

### rtl/tdre_disp_if.sv
// Display byte channel: valid/ready handshake with the byte payload.
// No dependencies.
interface tdre_disp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_command;
  logic       last;

  modport source (
    output valid, out_byte, is_command, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_command, last,
    output ready
  );
endinterface

### rtl/tdre_store.sv
// Text store: LINES x COLUMNS byte memory, one write and one registered read port.
// Per-entry valid bits make unwritten or cleared entries read as a space. Uses tdre_pkg.
module tdre_store
  import tdre_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  store_ctl_t                             ctl,
  input  logic [$clog2(LINES*COLUMNS)-1:0]       rd_addr,
  input  logic [$clog2(LINES*COLUMNS)-1:0]       wr_addr,
  input  logic [7:0]                             wr_data,
  output logic [7:0]                             rd_data
);

  localparam int DEPTH  = LINES * COLUMNS;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vbits;
  logic [7:0]       rdata;
  logic             rvalid;

  // Memory array, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Valid bits: reset and line clear invalidate, a write validates
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits  <= '0;
      rvalid <= 1'b0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ctl.clr_en && (i / COLUMNS) == int'(ctl.clr_line)) begin
          vbits[i] <= 1'b0;
        end
      end
      if (ctl.wr_en) begin
        vbits[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rvalid <= vbits[rd_addr];
      end
    end
  end

  assign rd_data = rvalid ? rdata : BLANK_CHAR;

endmodule

### rtl/tdre_hash.sv
// djb2 line hash unit: byte-serial accumulator plus the last-sent hash per line.
// Uses tdre_pkg.
module tdre_hash
  import tdre_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hash_ctl_t         ctl,
  input  logic [LINE_W-1:0] line,
  input  logic [7:0]        data,
  output logic              differs
);

  localparam logic [31:0] BLANK_HASH = blank_hash(COLUMNS);

  logic [31:0] acc;
  logic [31:0] sent [LINES];

  // Accumulator: hash = hash * 33 + byte
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= HASH_SEED;
    end else if (ctl.acc_en) begin
      acc <= (acc << 5) + acc + 32'(data);
    end
  end

  // Hash of the contents last sent per line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        sent[i] <= BLANK_HASH;
      end
    end else if (ctl.store_en) begin
      sent[line] <= acc;
    end
  end

  assign differs = (acc != sent[line]);

endmodule

### rtl/text_display_refresh_engine.sv
// Text display refresh engine top level: control sequencer, cursor, dirty flags, output register.
// Uses tdre_pkg, tdre_host_if, tdre_disp_if, tdre_store, tdre_hash and the assert header.
//
// Usage:
//   host: operations (set_pos, put_char, clear_line, right_justify, refresh_line).
//   disp: bytes for the display controller, one transaction per byte; a refresh burst
//         is the line address command followed by COLUMNS data bytes, last on the final one.
//   set_pos, clear_line, right_justify and unknown codes complete in the idle state;
//   put_char reads the text store, then compares and writes back, and a dropped
//   character completes in the idle state. A refresh of a line that is not dirty
//   completes in the idle state; a dirty line is first hashed through the store's
//   single read port, then, if the hash changed, the command is sent, and each data
//   byte takes a store read, then a load of the output register.
//   host.ready is high only while the sequencer is idle.
//   Reset: text reads as spaces (per-entry valid bits clear at once, no clearing pass),
//   dirty flags cleared, stored hashes set to the blank-line hash, cursor at line 0 col 0.
//   When disp stalls, the output register holds its byte and the burst waits; the
//   final byte may still sit in the output register while the next operation is taken.
module text_display_refresh_engine
  import tdre_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  tdre_host_if.sink   host,
  tdre_disp_if.source disp
);

  localparam int DEPTH  = LINES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam logic [COL_W-1:0]  COL_END  = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [7:0]        COLS8    = 8'(COLUMNS);
  localparam logic [LINE_W-1:0] LINE_TOP = LINE_W'(LINES - 1);

  function automatic logic [ADDR_W-1:0] line_base(logic [LINE_W-1:0] ln);
    return ADDR_W'(ln * COLUMNS);
  endfunction

  state_t state, state_next;

  logic [LINE_W-1:0] cursor_line;
  logic [COL_W-1:0]  cursor_col;
  logic [LINES-1:0]  dirty;
  logic [LINE_W-1:0] ref_line;
  logic [COL_W-1:0]  cnt;
  logic              rd_pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]        pend_char;
  logic [LINE_W-1:0] pend_line;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_cmd;
  logic       out_last;

  store_ctl_t        st_ctl;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        st_rdata;
  hash_ctl_t         hctl;
  logic              hash_diff;

  logic              host_acc;
  op_t               op;
  logic              out_free;
  logic              at_end;
  logic              put_drop;
  logic [LINE_W-1:0] eff_line;
  logic [COL_W-1:0]  eff_col;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] ref_addr;
  logic              emit_last;
  logic              ref_send;
  logic              out_load;
  logic [7:0]        load_byte;
  logic              load_cmd;
  logic              load_last;

  // Handshake and decode
  assign host.ready = (state == S_IDLE);
  assign host_acc   = host.valid && host.ready;
  assign op         = op_t'(host.operation);
  assign out_free   = !out_valid || disp.ready;

  // put_char target after optional wrap
  assign at_end   = (cursor_col >= COL_END);
  assign put_drop = at_end && !(host.wrap && cursor_line != LINE_TOP);
  assign eff_line = at_end ? cursor_line + 1'b1 : cursor_line;
  assign eff_col  = at_end ? '0 : cursor_col;
  assign put_addr = line_base(eff_line) + ADDR_W'(eff_col);

  assign ref_addr  = line_base(ref_line) + ADDR_W'(cnt);
  assign emit_last = (cnt == COL_LAST);
  // line hash changed: burst goes out
  assign ref_send  = (state == S_CMP) && hash_diff;

  tdre_store #(.COLUMNS(COLUMNS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (st_ctl),
    .rd_addr (rd_addr),
    .wr_addr (pend_addr),
    .wr_data (pend_char),
    .rd_data (st_rdata)
  );

  tdre_hash #(.COLUMNS(COLUMNS)) u_hash (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .line    (ref_line),
    .data    (st_rdata),
    .differs (hash_diff)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (host_acc) begin
          if (op == OP_PUT_CHAR && !put_drop) begin
            state_next = S_PUT_CMP;
          end else if (op == OP_REFRESH_LINE && dirty[host.line_sel]) begin
            state_next = S_HASH;
          end
        end
      end
      S_PUT_CMP:  state_next = S_IDLE;
      S_HASH: begin
        if (emit_last) begin
          state_next = S_HASH_END;
        end
      end
      S_HASH_END: state_next = S_CMP;
      S_CMP:      state_next = hash_diff ? S_CMD : S_IDLE;
      S_CMD: begin
        if (out_free) begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        if (out_free) begin
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD:  state_next = emit_last ? S_IDLE : S_EMIT_RD;
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: store, hash and output register controls
  always_comb begin
    st_ctl    = '0;
    rd_addr   = ref_addr;
    hctl      = '0;
    out_load  = 1'b0;
    load_byte = st_rdata;
    load_cmd  = 1'b0;
    load_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (host_acc) begin
          case (op)
            OP_PUT_CHAR: begin
              st_ctl.rd_en = !put_drop;
              rd_addr      = put_addr;
            end
            OP_CLEAR_LINE: begin
              st_ctl.clr_en   = 1'b1;
              st_ctl.clr_line = host.line_sel;
            end
            OP_REFRESH_LINE: hctl.start = dirty[host.line_sel];
            default: ;
          endcase
        end
      end
      S_PUT_CMP:  st_ctl.wr_en = (st_rdata != pend_char);
      S_HASH: begin
        st_ctl.rd_en = 1'b1;
        hctl.acc_en  = rd_pend;
      end
      S_HASH_END: hctl.acc_en   = 1'b1;
      S_CMP:      hctl.store_en = hash_diff;
      S_CMD: begin
        out_load  = out_free;
        load_byte = line_cmd(ref_line);
        load_cmd  = 1'b1;
      end
      S_EMIT_RD:  st_ctl.rd_en = out_free;
      S_EMIT_LD: begin
        out_load  = 1'b1;
        load_last = emit_last;
      end
      default: ;
    endcase
  end

  // Cursor, pending write and refresh bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cursor_line <= '0;
      cursor_col  <= '0;
      dirty       <= '0;
      rd_pend     <= 1'b0;
      cnt         <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= st_ctl.rd_en;
      if (host_acc) begin
        case (op)
          OP_SET_POS: begin
            if (host.column_sel < 5'(COLUMNS)) begin
              cursor_col <= COL_W'(host.column_sel);
            end
            cursor_line <= host.line_sel;
          end
          OP_PUT_CHAR: begin
            if (!put_drop) begin
              cursor_line <= eff_line;
              cursor_col  <= eff_col + 1'b1;
            end
          end
          OP_CLEAR_LINE: dirty[host.line_sel] <= 1'b1;
          OP_RIGHT_JUSTIFY: begin
            cursor_col <= (host.text_length < COLS8) ?
                          COL_W'(COLUMNS - int'(host.text_length)) : '0;
          end
          OP_REFRESH_LINE: cnt <= '0;
          default: ;
        endcase
      end
      if (st_ctl.wr_en) begin
        dirty[pend_line] <= 1'b1;
      end
      if (ref_send) begin
        dirty[ref_line] <= 1'b0;
      end
      if (state == S_HASH || state == S_EMIT_LD) begin
        cnt <= emit_last ? '0 : cnt + 1'b1;
      end
    end
  end

  // Payload of the pending put_char and the line being refreshed
  always_ff @(posedge clk) begin
    if (host_acc) begin
      pend_addr <= put_addr;
      pend_char <= host.char_code;
      pend_line <= eff_line;
      ref_line  <= host.line_sel;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (disp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= load_byte;
      out_cmd  <= load_cmd;
      out_last <= load_last;
    end
  end

  assign disp.valid      = out_valid;
  assign disp.out_byte   = out_byte;
  assign disp.is_command = out_cmd;
  assign disp.last       = out_last;

  `include "text_display_refresh_engine_assert.svh"

  `TDRE_ASSERT_IMPL(a_emit_ld_ready, state == S_EMIT_LD, rd_pend && !out_valid, "bad byte load")
  `TDRE_ASSERT_IMPL(a_no_overwrite, out_load, out_free, "output register overwritten")
  `TDRE_ASSERT_NEXT(a_refresh_clears, ref_send, state == S_CMD && !dirty[ref_line], "flag kept")
  `TDRE_ASSERT_IMPL(a_cnt_range, state != S_IDLE, cnt < COL_END, "column counter out of range")
  `TDRE_ASSERT_NEXT(a_write_marks_dirty, st_ctl.wr_en, dirty[$past(pend_line)], "line left clean")

endmodule
